// ===== sv/kte_pkg.sv =====
// Shared types, codes and helper functions for the keypad time/date entry block.
// No dependencies; used by every module of the block.

package kte_pkg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_DIGIT = 2'd1,
        OP_LEFT  = 2'd2,
        OP_RIGHT = 2'd3
    } op_t;

    // Digit positions in display order HH MM SS YYYY MM DD
    localparam logic [3:0] POS_HOUR_TENS   = 4'd0;
    localparam logic [3:0] POS_HOUR_UNITS  = 4'd1;
    localparam logic [3:0] POS_MIN_TENS    = 4'd2;
    localparam logic [3:0] POS_MIN_UNITS   = 4'd3;
    localparam logic [3:0] POS_SEC_TENS    = 4'd4;
    localparam logic [3:0] POS_SEC_UNITS   = 4'd5;
    localparam logic [3:0] POS_YEAR_THOUS  = 4'd6;
    localparam logic [3:0] POS_YEAR_HUNDS  = 4'd7;
    localparam logic [3:0] POS_YEAR_TENS   = 4'd8;
    localparam logic [3:0] POS_YEAR_UNITS  = 4'd9;
    localparam logic [3:0] POS_MONTH_TENS  = 4'd10;
    localparam logic [3:0] POS_MONTH_UNITS = 4'd11;
    localparam logic [3:0] POS_DAY_TENS    = 4'd12;
    localparam logic [3:0] POS_DAY_UNITS   = 4'd13;

    localparam logic [3:0] POS_FIRST = POS_HOUR_TENS;
    localparam logic [3:0] POS_LAST  = POS_DAY_UNITS;

    localparam logic [4:0] RESET_DAY = 5'd1;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [7:0] year;   // years since 1900
        logic [3:0] month;  // month minus one
        logic [4:0] day;
    } datetime_t;

    typedef struct packed {
        logic      ok;
        datetime_t value;
    } edit_result_t;

    // x / 10 by reciprocal, exact for all 8-bit x
    function automatic logic [4:0] div10(input logic [7:0] x);
        logic [15:0] prod;
        prod = 16'(x) * 16'd205;
        return prod[15:11];
    endfunction

    function automatic logic [3:0] mod10(input logic [7:0] x);
        logic [7:0] q10;
        q10 = 8'(div10(x)) * 8'd10;
        return 4'(x - q10);
    endfunction

    // Month length, no leap years; codes past December have no days
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1:                      len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            4'd0, 4'd2, 4'd4, 4'd6,
            4'd7, 4'd9, 4'd11:         len = 5'd31;
            default:                   len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/kte_digit_edit.sv =====
// Digit edit decision: applies one key digit at the cursor position and checks ranges.
// Depends on kte_pkg.

module kte_digit_edit (
    input  kte_pkg::datetime_t    cur,
    input  logic [3:0]            cursor,
    input  logic [3:0]            digit,
    output kte_pkg::edit_result_t result
);

    logic [8:0] n10;
    logic [4:0] hr_t;
    logic [3:0] hr_u;
    logic [4:0] mi_t;
    logic [3:0] mi_u;
    logic [4:0] se_t;
    logic [3:0] se_u;
    logic [1:0] yr_h;
    logic [7:0] yr_r;
    logic [3:0] yr_ru;
    logic [3:0] yr_u;
    logic [4:0] mp1;
    logic       mp1_t;
    logic [3:0] mp1_u;
    logic [4:0] len;
    logic [4:0] len_t;
    logic [3:0] len_u;
    logic [4:0] dy_t;
    logic [3:0] dy_u;

    logic [8:0] hr_tens_sum, hr_unit_sum;
    logic [8:0] mi_tens_sum, mi_unit_sum;
    logic [8:0] se_tens_sum, se_unit_sum;
    logic [8:0] yr_tens_sum, yr_unit_sum;
    logic [8:0] mo_tens_sum, mo_unit_sum;
    logic [8:0] dy_tens_sum, dy_unit_sum;
    logic [3:0] mo_tens_new, mo_unit_new;
    logic       digit_ok;

    assign digit_ok = digit <= 4'd9;
    assign n10      = 9'(digit) * 9'd10;

    assign hr_t = kte_pkg::div10(8'(cur.hour));
    assign hr_u = kte_pkg::mod10(8'(cur.hour));
    assign mi_t = kte_pkg::div10(8'(cur.minute));
    assign mi_u = kte_pkg::mod10(8'(cur.minute));
    assign se_t = kte_pkg::div10(8'(cur.second));
    assign se_u = kte_pkg::mod10(8'(cur.second));

    assign yr_h  = (cur.year >= 8'd200) ? 2'd2 : ((cur.year >= 8'd100) ? 2'd1 : 2'd0);
    assign yr_r  = (cur.year >= 8'd200) ? cur.year - 8'd200 :
                   ((cur.year >= 8'd100) ? cur.year - 8'd100 : cur.year);
    assign yr_ru = kte_pkg::mod10(yr_r);
    assign yr_u  = kte_pkg::mod10(cur.year);

    // month shown as 1..12 on the display
    assign mp1   = 5'(cur.month) + 5'd1;
    assign mp1_t = mp1 >= 5'd10;
    assign mp1_u = mp1_t ? 4'(mp1 - 5'd10) : mp1[3:0];

    assign len   = kte_pkg::month_len(cur.month);
    assign len_t = kte_pkg::div10(8'(len));
    assign len_u = kte_pkg::mod10(8'(len));
    assign dy_t  = kte_pkg::div10(8'(cur.day));
    assign dy_u  = kte_pkg::mod10(8'(cur.day));

    assign hr_tens_sum = n10 + 9'(hr_u);
    assign hr_unit_sum = 9'(hr_t) * 9'd10 + 9'(digit);
    assign mi_tens_sum = n10 + 9'(mi_u);
    assign mi_unit_sum = 9'(mi_t) * 9'd10 + 9'(digit);
    assign se_tens_sum = n10 + 9'(se_u);
    assign se_unit_sum = 9'(se_t) * 9'd10 + 9'(digit);
    assign yr_tens_sum = 9'(yr_h) * 9'd100 + n10 + 9'(yr_ru);
    assign yr_unit_sum = 9'(cur.year) - 9'(yr_u) + 9'(digit);
    assign mo_tens_sum = n10 + 9'(mp1_u);
    assign mo_unit_sum = (mp1_t ? 9'd10 : 9'd0) + 9'(digit);
    assign dy_tens_sum = n10 + 9'(dy_u);
    assign dy_unit_sum = 9'(dy_t) * 9'd10 + 9'(digit);

    assign mo_tens_new = 4'(mo_tens_sum - 9'd1);
    assign mo_unit_new = 4'(mo_unit_sum - 9'd1);

    always_comb
    begin
        result.value = cur;
        result.ok    = 1'b0;
        case (cursor)
            kte_pkg::POS_HOUR_TENS:
            begin
                result.ok         = digit < 4'd3 && hr_tens_sum <= 9'd23;
                result.value.hour = hr_tens_sum[4:0];
            end
            kte_pkg::POS_HOUR_UNITS:
            begin
                result.ok         = (cur.hour < 5'd20 || digit < 4'd4) &&
                                    hr_unit_sum <= 9'd23;
                result.value.hour = hr_unit_sum[4:0];
            end
            kte_pkg::POS_MIN_TENS:
            begin
                result.ok           = digit < 4'd6 && mi_tens_sum <= 9'd59;
                result.value.minute = mi_tens_sum[5:0];
            end
            kte_pkg::POS_MIN_UNITS:
            begin
                result.ok           = mi_unit_sum <= 9'd59;
                result.value.minute = mi_unit_sum[5:0];
            end
            kte_pkg::POS_SEC_TENS:
            begin
                result.ok           = digit < 4'd6 && se_tens_sum <= 9'd59;
                result.value.second = se_tens_sum[5:0];
            end
            kte_pkg::POS_SEC_UNITS:
            begin
                result.ok           = se_unit_sum <= 9'd59;
                result.value.second = se_unit_sum[5:0];
            end
            kte_pkg::POS_YEAR_THOUS:
            begin
                result.ok         = digit == 4'd1 || digit == 4'd2;
                result.value.year = (digit == 4'd2) ? yr_r + 8'd100 : yr_r;
            end
            kte_pkg::POS_YEAR_HUNDS:
            begin
                // 19xx accepts a 9, 20xx accepts a 0
                if (digit == 4'd9 && cur.year < 8'd100)
                begin
                    result.ok         = 1'b1;
                    result.value.year = yr_r;
                end
                else if (digit == 4'd0 && cur.year >= 8'd100)
                begin
                    result.ok         = 1'b1;
                    result.value.year = yr_r + 8'd100;
                end
            end
            kte_pkg::POS_YEAR_TENS:
            begin
                result.ok         = yr_tens_sum <= 9'd199;
                result.value.year = yr_tens_sum[7:0];
            end
            kte_pkg::POS_YEAR_UNITS:
            begin
                result.ok         = yr_unit_sum <= 9'd199;
                result.value.year = yr_unit_sum[7:0];
            end
            kte_pkg::POS_MONTH_TENS:
            begin
                result.ok          = digit < 4'd2 && mo_tens_sum >= 9'd1 &&
                                     mo_tens_sum <= 9'd12 &&
                                     cur.day <= kte_pkg::month_len(mo_tens_new);
                result.value.month = mo_tens_new;
            end
            kte_pkg::POS_MONTH_UNITS:
            begin
                result.ok          = (cur.month >= 4'd9 ? digit < 4'd3 : digit > 4'd0) &&
                                     mo_unit_sum >= 9'd1 && mo_unit_sum <= 9'd12 &&
                                     cur.day <= kte_pkg::month_len(mo_unit_new);
                result.value.month = mo_unit_new;
            end
            kte_pkg::POS_DAY_TENS:
            begin
                result.ok        = 5'(digit) <= len_t && dy_tens_sum >= 9'd1 &&
                                   dy_tens_sum <= 9'(len);
                result.value.day = dy_tens_sum[4:0];
            end
            default:
            begin
                // day units; cap the units only when the tens already match the month
                result.ok        = (dy_t != len_t || digit <= len_u) &&
                                   dy_unit_sum >= 9'd1 && dy_unit_sum <= 9'(len);
                result.value.day = dy_unit_sum[4:0];
            end
        endcase
        result.ok = result.ok && digit_ok;
    end

endmodule

// ===== sv/keypad_time_date_entry_core.sv =====
// Keypad time/date entry: input register, edit state, result register.
// An item taken at the input is held in the input register, then its edit result in the result
// register; throughput one item per cycle while the output is not stalled.
// The edit state and cursor update in the cycle an item leaves the input register,
// so the next item sees them at once. Stalls on the output back up into the input.
// Asynchronous active-low reset: time 00:00:00, year 1900, January 1, cursor 0.
// Depends on kte_pkg and kte_digit_edit.

module keypad_time_date_entry_core (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [3:0] key_digit,
    input  logic [4:0] load_hour,
    input  logic [5:0] load_minute,
    input  logic [5:0] load_second,
    input  logic [7:0] load_year,
    input  logic [3:0] load_month,
    input  logic [4:0] load_day,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] hour_out,
    output logic [5:0] minute_out,
    output logic [5:0] second_out,
    output logic [7:0] year_out,
    output logic [3:0] month_out,
    output logic [4:0] day_out,
    output logic [3:0] cursor_out,
    output logic       accepted,
    output logic       modified
);

    logic               s1_valid_reg;
    kte_pkg::op_t       s1_op_reg;
    logic [3:0]         s1_digit_reg;
    kte_pkg::datetime_t s1_load_reg;

    kte_pkg::datetime_t cur_reg, cur_next;
    kte_pkg::datetime_t ref_reg, ref_next;
    logic [3:0]         cursor_reg, cursor_next;
    logic               acc_next;

    logic               out_valid_reg;
    kte_pkg::datetime_t out_time_reg;
    logic [3:0]         out_cursor_reg;
    logic               out_acc_reg;
    logic               out_mod_reg;

    kte_pkg::edit_result_t edit;
    kte_pkg::datetime_t    reset_time;
    logic                  out_free;
    logic                  s1_fire;
    logic                  in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign reset_time = '{hour: 5'd0, minute: 6'd0, second: 6'd0, year: 8'd0,
                          month: 4'd0, day: kte_pkg::RESET_DAY};

    kte_digit_edit u_edit (
        .cur    (cur_reg),
        .cursor (cursor_reg),
        .digit  (s1_digit_reg),
        .result (edit)
    );

    always_comb
    begin
        cur_next    = cur_reg;
        ref_next    = ref_reg;
        cursor_next = cursor_reg;
        acc_next    = 1'b0;
        case (s1_op_reg)
            kte_pkg::OP_LOAD:
            begin
                cur_next    = s1_load_reg;
                ref_next    = s1_load_reg;
                cursor_next = kte_pkg::POS_FIRST;
            end
            kte_pkg::OP_DIGIT:
            begin
                acc_next = edit.ok;
                if (edit.ok)
                begin
                    cur_next = edit.value;
                    if (cursor_reg < kte_pkg::POS_LAST)
                        cursor_next = cursor_reg + 4'd1;
                end
            end
            kte_pkg::OP_LEFT:
            begin
                if (cursor_reg > kte_pkg::POS_FIRST)
                    cursor_next = cursor_reg - 4'd1;
            end
            default:
            begin
                if (cursor_reg < kte_pkg::POS_LAST)
                    cursor_next = cursor_reg + 4'd1;
            end
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take || s1_fire)
            s1_valid_reg <= in_take;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg    <= kte_pkg::op_t'(operation);
            s1_digit_reg <= key_digit;
            s1_load_reg  <= '{hour: load_hour, minute: load_minute, second: load_second,
                              year: load_year, month: load_month, day: load_day};
        end
    end

    // edit state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg    <= reset_time;
            ref_reg    <= reset_time;
            cursor_reg <= kte_pkg::POS_FIRST;
        end
        else if (s1_fire)
        begin
            cur_reg    <= cur_next;
            ref_reg    <= ref_next;
            cursor_reg <= cursor_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_time_reg   <= cur_next;
            out_cursor_reg <= cursor_next;
            out_acc_reg    <= acc_next;
            out_mod_reg    <= cur_next != ref_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hour_out   = out_time_reg.hour;
    assign minute_out = out_time_reg.minute;
    assign second_out = out_time_reg.second;
    assign year_out   = out_time_reg.year;
    assign month_out  = out_time_reg.month;
    assign day_out    = out_time_reg.day;
    assign cursor_out = out_cursor_reg;
    assign accepted   = out_acc_reg;
    assign modified   = out_mod_reg;

endmodule

// ===== sv/kte_checker.sv =====
// Port-level checks for keypad_time_date_entry_core, attached by bind.
// Depends on kte_pkg.

module kte_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [4:0] hour_out,
    input logic [5:0] minute_out,
    input logic [5:0] second_out,
    input logic [7:0] year_out,
    input logic [3:0] month_out,
    input logic [4:0] day_out,
    input logic [3:0] cursor_out,
    input logic       accepted,
    input logic       modified
);

    logic [3:0] last_cursor_reg;
    logic       out_xfer;

    assign out_xfer = out_valid && !out_stall;

    // cursor as of the last result transfer; reset homes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_cursor_reg <= kte_pkg::POS_FIRST;
        else if (out_xfer)
            last_cursor_reg <= cursor_out;
    end

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cursor_out <= kte_pkg::POS_LAST)
        else $error("cursor past last digit position");

    a_accept_advances: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && accepted && last_cursor_reg < kte_pkg::POS_LAST
        |-> cursor_out == last_cursor_reg + 4'd1)
        else $error("accepted digit did not advance the cursor");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hour_out) && $stable(minute_out)
        && $stable(second_out) && $stable(year_out) && $stable(month_out)
        && $stable(day_out) && $stable(cursor_out) && $stable(accepted)
        && $stable(modified))
        else $error("stalled result changed");

endmodule

bind keypad_time_date_entry_core kte_checker u_kte_checker (.*);

// ===== verif/tb_keypad_time_date_entry_core.sv =====
// Self-checking testbench for keypad_time_date_entry_core: random load/digit/cursor traffic,
// random stalls on both sides, results checked against an in-bench model of the entry rules.
// Depends on kte_pkg and the keypad_time_date_entry_core RTL.

module tb_keypad_time_date_entry_core;

    typedef struct {
        kte_pkg::op_t op;
        logic [3:0]   digit;
        logic [4:0]   hour;
        logic [5:0]   minute;
        logic [5:0]   second;
        logic [7:0]   year;
        logic [3:0]   month;
        logic [4:0]   day;
    } key_event_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [3:0] cursor;
        logic       accepted;
        logic       modified;
    } readout_t;

    localparam int RANDOM_EVENTS  = 1550;
    localparam int CALM_TAIL      = 150;
    localparam int HOLDOFF_AFTER  = 300;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;
    localparam int DAYS_IN_MONTH [16] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31,
                                          0, 0, 0, 0};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] operation = '0;
    logic [3:0] key_digit = '0;
    logic [4:0] load_hour = '0;
    logic [5:0] load_minute = '0;
    logic [5:0] load_second = '0;
    logic [7:0] load_year = '0;
    logic [3:0] load_month = '0;
    logic [4:0] load_day = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [4:0] hour_out;
    logic [5:0] minute_out;
    logic [5:0] second_out;
    logic [7:0] year_out;
    logic [3:0] month_out;
    logic [4:0] day_out;
    logic [3:0] cursor_out;
    logic       accepted;
    logic       modified;

    keypad_time_date_entry_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .key_digit   (key_digit),
        .load_hour   (load_hour),
        .load_minute (load_minute),
        .load_second (load_second),
        .load_year   (load_year),
        .load_month  (load_month),
        .load_day    (load_day),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hour_out    (hour_out),
        .minute_out  (minute_out),
        .second_out  (second_out),
        .year_out    (year_out),
        .month_out   (month_out),
        .day_out     (day_out),
        .cursor_out  (cursor_out),
        .accepted    (accepted),
        .modified    (modified)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    key_event_t pending_events [$];
    readout_t   expected_readouts [$];

    // Edited time, its loaded copy and the cursor, as the block should hold them
    int         e_hour = 0, e_minute = 0, e_second = 0, e_year = 0, e_month = 0, e_day = 1;
    int         r_hour = 0, r_minute = 0, r_second = 0, r_year = 0, r_month = 0, r_day = 1;
    logic [3:0] e_cursor = kte_pkg::POS_FIRST;

    int total_events;
    int results_seen;
    int mismatches;
    int load_count, digit_count, move_count, digits_taken;

    logic calm_tail = 1'b0;
    int   send_gap, send_idle_pct, send_phase;
    bit   offer;
    int   recv_gap, recv_idle_pct, recv_phase, recv_count, holdoff_left;
    bit   holdoff_done, hold;
    int   quiet_cycles;
    readout_t seen, want, fresh;
    key_event_t taken;

    function automatic int month_days(int m);
        return DAYS_IN_MONTH[m & 15];
    endfunction

    // Apply one digit key at the cursor; returns 1 when the edit is taken
    function automatic bit try_digit(int n);
        int  h, mi, s, y, mo, d, len;
        bit  ok;
        h   = e_hour;
        mi  = e_minute;
        s   = e_second;
        y   = e_year;
        mo  = e_month;
        d   = e_day;
        len = month_days(e_month);
        ok  = 1'b0;
        if (n > 9)
            return 1'b0;
        case (e_cursor)
            kte_pkg::POS_HOUR_TENS:
            begin
                h  = n * 10 + e_hour % 10;
                ok = n < 3 && h <= 23;
            end
            kte_pkg::POS_HOUR_UNITS:
            begin
                h  = (e_hour / 10) * 10 + n;
                ok = (e_hour >= 20 ? n < 4 : 1'b1) && h <= 23;
            end
            kte_pkg::POS_MIN_TENS:
            begin
                mi = n * 10 + e_minute % 10;
                ok = n < 6 && mi <= 59;
            end
            kte_pkg::POS_MIN_UNITS:
            begin
                mi = (e_minute / 10) * 10 + n;
                ok = mi <= 59;
            end
            kte_pkg::POS_SEC_TENS:
            begin
                s  = n * 10 + e_second % 10;
                ok = n < 6 && s <= 59;
            end
            kte_pkg::POS_SEC_UNITS:
            begin
                s  = (e_second / 10) * 10 + n;
                ok = s <= 59;
            end
            kte_pkg::POS_YEAR_THOUS:
            begin
                y  = (n - 1) * 100 + e_year % 100;
                ok = (n == 1 || n == 2) && y >= 0 && y <= 199;
            end
            kte_pkg::POS_YEAR_HUNDS:
            begin
                // 9 only before 2000, 0 only from 2000 on
                if (n == 9 && e_year < 100)
                begin
                    y  = e_year % 100;
                    ok = 1'b1;
                end
                else if (n == 0 && e_year >= 100)
                begin
                    y  = e_year % 100 + 100;
                    ok = 1'b1;
                end
                ok = ok && y <= 199;
            end
            kte_pkg::POS_YEAR_TENS:
            begin
                y  = (e_year / 100) * 100 + n * 10 + e_year % 10;
                ok = y <= 199;
            end
            kte_pkg::POS_YEAR_UNITS:
            begin
                y  = (e_year / 10) * 10 + n;
                ok = y <= 199;
            end
            kte_pkg::POS_MONTH_TENS:
            begin
                mo = n * 10 + (e_month + 1) % 10 - 1;
                ok = n < 2 && mo >= 0 && mo <= 11 && e_day <= month_days(mo);
            end
            kte_pkg::POS_MONTH_UNITS:
            begin
                mo = ((e_month + 1) / 10) * 10 + n - 1;
                ok = (e_month >= 9 ? n < 3 : n > 0) && mo >= 0 && mo <= 11
                     && e_day <= month_days(mo);
            end
            kte_pkg::POS_DAY_TENS:
            begin
                d  = n * 10 + e_day % 10;
                ok = n <= len / 10 && d >= 1 && d <= len;
            end
            default:
            begin
                d  = (e_day / 10) * 10 + n;
                ok = (e_day / 10 == len / 10 ? n <= len % 10 : 1'b1) && d >= 1 && d <= len;
            end
        endcase
        if (ok)
        begin
            e_hour   = h;
            e_minute = mi;
            e_second = s;
            e_year   = y;
            e_month  = mo;
            e_day    = d;
        end
        return ok;
    endfunction

    function automatic readout_t advance_entry(key_event_t ev);
        readout_t ro;
        bit       took;
        took = 1'b0;
        case (ev.op)
            kte_pkg::OP_LOAD:
            begin
                e_hour   = ev.hour;
                e_minute = ev.minute;
                e_second = ev.second;
                e_year   = ev.year;
                e_month  = ev.month;
                e_day    = ev.day;
                r_hour   = e_hour;
                r_minute = e_minute;
                r_second = e_second;
                r_year   = e_year;
                r_month  = e_month;
                r_day    = e_day;
                e_cursor = kte_pkg::POS_FIRST;
            end
            kte_pkg::OP_DIGIT:
            begin
                took = try_digit(ev.digit);
                if (took && e_cursor != kte_pkg::POS_LAST)
                    e_cursor = e_cursor + 4'd1;
            end
            kte_pkg::OP_LEFT:
            begin
                if (e_cursor != kte_pkg::POS_FIRST)
                    e_cursor = e_cursor - 4'd1;
            end
            default:
            begin
                if (e_cursor != kte_pkg::POS_LAST)
                    e_cursor = e_cursor + 4'd1;
            end
        endcase
        ro.hour     = 5'(e_hour);
        ro.minute   = 6'(e_minute);
        ro.second   = 6'(e_second);
        ro.year     = 8'(e_year);
        ro.month    = 4'(e_month);
        ro.day      = 5'(e_day);
        ro.cursor   = e_cursor;
        ro.accepted = took;
        ro.modified = e_hour != r_hour || e_minute != r_minute || e_second != r_second
                      || e_year != r_year || e_month != r_month || e_day != r_day;
        return ro;
    endfunction

    // Load fields are don't-care on key and cursor items, so fill them with noise
    function automatic void queue_event(kte_pkg::op_t op, int digit);
        key_event_t ev;
        ev.op     = op;
        ev.digit  = 4'(digit);
        ev.hour   = 5'($urandom);
        ev.minute = 6'($urandom);
        ev.second = 6'($urandom);
        ev.year   = 8'($urandom);
        ev.month  = 4'($urandom);
        ev.day    = 5'($urandom);
        pending_events.push_back(ev);
    endfunction

    function automatic void queue_load(int h, int mi, int s, int y, int mo, int d, int digit);
        key_event_t ev;
        ev.op     = kte_pkg::OP_LOAD;
        ev.digit  = 4'(digit);
        ev.hour   = 5'(h);
        ev.minute = 6'(mi);
        ev.second = 6'(s);
        ev.year   = 8'(y);
        ev.month  = 4'(mo);
        ev.day    = 5'(d);
        pending_events.push_back(ev);
    endfunction

    // Mostly legal small digits so that walks get past the tens positions
    function automatic int random_key();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return $urandom_range(2);
        else if (pick < 92)
            return $urandom_range(9);
        return $urandom_range(15, 10);
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(3))
            0, 1:    return 0;
            2:       return 10;
            default: return 35;
        endcase
    endfunction

    // Sender: holds a stalled transfer, otherwise offers the next item or idles a burst
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                void'(pending_events.pop_front());
            send_phase++;
            if (send_phase % 128 == 0)
                send_idle_pct = pick_idle_pct();
            calm_tail <= pending_events.size() < CALM_TAIL;
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    offer = 1'b0;
                end
                else if (!calm_tail && $urandom_range(99) < send_idle_pct)
                begin
                    send_gap = $urandom_range(11);
                    offer    = 1'b0;
                end
                else
                begin
                    offer = pending_events.size() != 0;
                end
                in_valid <= offer;
                if (offer)
                begin
                    operation   <= pending_events[0].op;
                    key_digit   <= pending_events[0].digit;
                    load_hour   <= pending_events[0].hour;
                    load_minute <= pending_events[0].minute;
                    load_second <= pending_events[0].second;
                    load_year   <= pending_events[0].year;
                    load_month  <= pending_events[0].month;
                    load_day    <= pending_events[0].day;
                end
            end
        end
    end

    // Receiver: random stall bursts plus one long hold-off to back the block up
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                recv_count++;
            recv_phase++;
            if (recv_phase % 128 == 0)
                recv_idle_pct = pick_idle_pct();
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                hold = 1'b1;
            end
            else if (!holdoff_done && recv_count >= HOLDOFF_AFTER)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES - 1;
                hold         = 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                hold = 1'b1;
            end
            else if (!calm_tail && $urandom_range(99) < recv_idle_pct)
            begin
                recv_gap = $urandom_range(11);
                hold     = 1'b1;
            end
            else
            begin
                hold = 1'b0;
            end
            out_stall <= hold;
        end
    end

    // Checks result transfers first, then predicts from the input transfer of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                seen = {hour_out, minute_out, second_out, year_out, month_out, day_out,
                        cursor_out, accepted, modified};
                if (expected_readouts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d with nothing expected: %p", results_seen, seen);
                end
                else
                begin
                    want = expected_readouts.pop_front();
                    if (seen !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"result %0d: expected %0d:%0d:%0d y%0d m%0d d%0d cur%0d ",
                                      "acc%0b mod%0b, got %0d:%0d:%0d y%0d m%0d d%0d cur%0d ",
                                      "acc%0b mod%0b"}, results_seen,
                                     want.hour, want.minute, want.second, want.year,
                                     want.month, want.day, want.cursor, want.accepted,
                                     want.modified, seen.hour, seen.minute, seen.second,
                                     seen.year, seen.month, seen.day, seen.cursor,
                                     seen.accepted, seen.modified);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                taken.op     = kte_pkg::op_t'(operation);
                taken.digit  = key_digit;
                taken.hour   = load_hour;
                taken.minute = load_minute;
                taken.second = load_second;
                taken.year   = load_year;
                taken.month  = load_month;
                taken.day    = load_day;
                fresh = advance_entry(taken);
                expected_readouts.push_back(fresh);
                case (taken.op)
                    kte_pkg::OP_LOAD:  load_count++;
                    kte_pkg::OP_DIGIT: digit_count++;
                    default:           move_count++;
                endcase
                digits_taken += fresh.accepted;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d of %0d results seen",
                     quiet_cycles, results_seen, total_events);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int walk_keys [17];
        int directed_count;
        int mo;
        int pick;

        walk_keys = '{3, 5, 9, 5, 9, 2, 0, 9, 9, 1, 3, 1, 2, 4, 3, 2, 0};
        send_idle_pct = pick_idle_pct();
        recv_idle_pct = pick_idle_pct();

        // Directed: clamps, key above nine, a full walk over 23:59:59 2099-12-31 with
        // rejects at the hour, month and day rules (a month change that strands day 31), odd loads
        queue_event(kte_pkg::OP_LEFT, 0);
        queue_event(kte_pkg::OP_DIGIT, 15);
        queue_load(23, 59, 59, 199, 11, 31, 15);
        queue_event(kte_pkg::OP_DIGIT, 2);
        queue_event(kte_pkg::OP_DIGIT, 4);
        foreach (walk_keys[i])
            queue_event(kte_pkg::OP_DIGIT, walk_keys[i]);
        queue_event(kte_pkg::OP_RIGHT, 0);
        queue_load(31, 63, 63, 255, 15, 31, 15);
        queue_load(0, 0, 0, 0, 0, 0, 0);
        directed_count = pending_events.size();

        // Random: a load, an optional cursor run, then a burst of mixed keys
        while (pending_events.size() < directed_count + RANDOM_EVENTS)
        begin
            if ($urandom_range(99) < 80)
            begin
                mo = $urandom_range(11);
                queue_load($urandom_range(23), $urandom_range(59), $urandom_range(59),
                           $urandom_range(199), mo, $urandom_range(DAYS_IN_MONTH[mo], 1),
                           $urandom);
            end
            else
            begin
                queue_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom);
            end
            if ($urandom_range(1))
                repeat ($urandom_range(13))
                    queue_event(kte_pkg::OP_RIGHT, $urandom);
            repeat ($urandom_range(24, 4))
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                    queue_event(kte_pkg::OP_DIGIT, random_key());
                else if (pick < 75)
                    queue_event(kte_pkg::OP_RIGHT, $urandom);
                else if (pick < 90)
                    queue_event(kte_pkg::OP_LEFT, $urandom);
                else if (pick < 95)
                    queue_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom);
                else
                    queue_event(kte_pkg::OP_DIGIT, 9);
            end
        end
        total_events = pending_events.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (results_seen < total_events)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_readouts.size() != 0)
        begin
            mismatches += expected_readouts.size();
            $display("%0d expected results never arrived", expected_readouts.size());
        end

        $display("covered %0d items: %0d loads, %0d digit keys (%0d taken), %0d cursor moves",
                 total_events, load_count, digit_count, digits_taken, move_count);
        $display("random stall bursts both sides plus one %0d-cycle output hold-off; %0d errors",
                 HOLDOFF_CYCLES, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== keypad_time_date_entry_core.f =====
sv/kte_pkg.sv
sv/kte_digit_edit.sv
sv/keypad_time_date_entry_core.sv
sv/kte_checker.sv
verif/tb_keypad_time_date_entry_core.sv
